// ===== sv/lldwa_pkg.sv =====
// ----------------------------------------------------------------------------
// lldwa_pkg
// shared widths, codes and types of the least-loaded dispatcher
// ----------------------------------------------------------------------------
`default_nettype none

package lldwa_pkg;

  localparam int CMD_W     = 1;
  localparam int SRC_W     = 16;
  localparam int WID_W     = 4;
  localparam int TAG_W     = 16;
  localparam int STAT_W    = 3;
  localparam int LOAD_W    = 16;
  localparam int CNT_W     = 16;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_MAX_WORKERS  = 16;
  localparam int DEF_SOURCE_SLOTS = 16;

  localparam logic [CMD_W-1:0] CMD_SUBMIT = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FINISH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FIFO_KEEP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKERS   = 1'b1;

  localparam logic [CFG_W-1:0] WORKERS_RESET = 5'd16;

  typedef enum logic [STAT_W-1:0] {
    ST_AFFINITY  = 3'd0,
    ST_LEAST     = 3'd1,
    ST_FULL      = 3'd2,
    ST_FIN_OK    = 3'd3,
    ST_FIN_UNDER = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SRC_SCAN,
    S_DECIDE,
    S_LOAD_SCAN,
    S_SRC_WR,
    S_LOAD_RD,
    S_LOAD_WR
  } state_t;

  typedef struct packed {
    logic [SRC_W-1:0] key;
    logic [CNT_W-1:0] pending;
    logic [WID_W-1:0] worker;
  } src_entry_t;

endpackage

`default_nettype wire

// ===== sv/lldwa_if.sv =====
// ----------------------------------------------------------------------------
// lldwa_if
// valid/ready channels for submit/finish items and dispatch results
// ----------------------------------------------------------------------------
`default_nettype none

interface lldwa_in_if import lldwa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [SRC_W-1:0] source_id;
  logic [WID_W-1:0] worker_id;
  logic [TAG_W-1:0] task_tag;

  modport source (output valid, cmd, source_id, worker_id, task_tag, input ready);
  modport sink   (input valid, cmd, source_id, worker_id, task_tag, output ready);
endinterface

interface lldwa_out_if import lldwa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WID_W-1:0]  assigned_worker;
  logic [STAT_W-1:0] status;
  logic [TAG_W-1:0]  tag_out;

  modport source (output valid, assigned_worker, status, tag_out, input ready);
  modport sink   (input valid, assigned_worker, status, tag_out, output ready);
endinterface

`default_nettype wire

// ===== sv/lldwa_load_mem.sv =====
// ----------------------------------------------------------------------------
// lldwa_load_mem
// per-worker pending load memory, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lldwa_load_mem import lldwa_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WORKERS,
  parameter int AW    = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [LOAD_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic      [LOAD_W-1:0] rdata
);

  logic [LOAD_W-1:0] mem_r [DEPTH];
  logic [LOAD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/lldwa_src_mem.sv =====
// ----------------------------------------------------------------------------
// lldwa_src_mem
// source affinity table: entry memory plus per-slot valid flags
// ----------------------------------------------------------------------------
`default_nettype none

module lldwa_src_mem import lldwa_pkg::*; #(
  parameter int SLOTS = DEF_SOURCE_SLOTS,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire src_entry_t       wdata,
  input  wire logic             wvalid,
  input  wire logic [AW-1:0]    raddr,
  output src_entry_t            rdata,
  output logic      [SLOTS-1:0] valid
);

  src_entry_t       mem_r [SLOTS];
  src_entry_t       rdata_r;
  logic [SLOTS-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= wvalid;
    end
  end

  assign rdata = rdata_r;
  assign valid = valid_r;

endmodule

`default_nettype wire

// ===== sv/least_loaded_dispatch_with_affinity.sv =====
// ----------------------------------------------------------------------------
// least_loaded_dispatch_with_affinity
// task dispatcher: least-loaded worker choice with per-source affinity
// ----------------------------------------------------------------------------
// One item is worked at a time. The source table is searched one slot per
// cycle through its single read port, then the worker's load is read and
// written back; this is the whole path of a finish item or of a submit that
// hits its source's recorded worker. A least-loaded submit adds a scan of the
// load memory over the n active workers (workers_in_use, clamped to
// 1..MAX_WORKERS). After reset a clearing pass zeroes all MAX_WORKERS entries
// of the load memory; no transaction is accepted during it, configuration
// writes are. A finished result may wait on the output while the next item
// is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module least_loaded_dispatch_with_affinity import lldwa_pkg::*; #(
  parameter int MAX_WORKERS  = DEF_MAX_WORKERS,
  parameter int SOURCE_SLOTS = DEF_SOURCE_SLOTS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  lldwa_in_if.sink                  in_chan,
  lldwa_out_if.source               out_chan,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int WAW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int SAW = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
  localparam int SCW = $clog2(SOURCE_SLOTS + 1);

  // configuration
  logic             fifo_keep_r;
  logic [CFG_W-1:0] wiu_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_keep_r <= 1'b1;
      wiu_r       <= WORKERS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_FIFO_KEEP: fifo_keep_r <= cfg_wdata[0];
        CFG_WORKERS:   wiu_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // active worker count, clamped to 1..MAX_WORKERS
  logic [CFG_W-1:0] n_act;
  always_comb begin
    if (wiu_r == '0) begin
      n_act = CFG_W'(1);
    end else if (32'(wiu_r) > 32'(MAX_WORKERS)) begin
      n_act = CFG_W'(MAX_WORKERS);
    end else begin
      n_act = wiu_r;
    end
  end

  // state and item registers
  state_t           state_r, state_nxt;
  logic [CMD_W-1:0] cmd_r;
  logic [SRC_W-1:0] src_r;
  logic [WID_W-1:0] wid_r;
  logic [TAG_W-1:0] tag_r;

  // source search results
  logic [SCW-1:0]   scan_r, scan_nxt;
  logic             found_r, found_nxt;
  logic [SAW-1:0]   slot_r, slot_nxt;
  logic             free_found_r, free_found_nxt;
  logic [SAW-1:0]   free_r, free_nxt;
  src_entry_t       ent_r, ent_nxt;

  // load scan
  logic [CFG_W-1:0]  lscan_r, lscan_nxt;
  logic [WID_W-1:0]  best_r, best_nxt;
  logic [LOAD_W-1:0] best_load_r, best_load_nxt;

  // decision
  logic [WID_W-1:0] tgt_r, tgt_nxt;
  status_t          status_r, status_nxt;
  logic [WAW-1:0]   clr_r, clr_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [WID_W-1:0]  out_worker_r, out_worker_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [TAG_W-1:0]  out_tag_r, out_tag_nxt;

  // memory ports
  logic              ld_we;
  logic [WAW-1:0]    ld_waddr;
  logic [LOAD_W-1:0] ld_wdata;
  logic [WAW-1:0]    ld_raddr;
  logic [LOAD_W-1:0] ld_rdata;

  logic                    sm_we;
  logic [SAW-1:0]          sm_waddr;
  src_entry_t              sm_wdata;
  logic                    sm_wvalid;
  logic [SAW-1:0]          sm_raddr;
  src_entry_t              sm_rdata;
  logic [SOURCE_SLOTS-1:0] sm_valid;

  lldwa_load_mem #(.DEPTH(MAX_WORKERS), .AW(WAW)) u_load (
    .clk   (clk),
    .we    (ld_we),
    .waddr (ld_waddr),
    .wdata (ld_wdata),
    .raddr (ld_raddr),
    .rdata (ld_rdata)
  );

  lldwa_src_mem #(.SLOTS(SOURCE_SLOTS), .AW(SAW)) u_src (
    .clk    (clk),
    .rst_n  (rst_n),
    .we     (sm_we),
    .waddr  (sm_waddr),
    .wdata  (sm_wdata),
    .wvalid (sm_wvalid),
    .raddr  (sm_raddr),
    .rdata  (sm_rdata),
    .valid  (sm_valid)
  );

  logic             accept;
  logic [SAW-1:0]   ev_slot;
  logic             ev_valid;
  logic [WID_W-1:0] ev_worker;
  logic             tgt_ok;
  logic [CNT_W-1:0] pend_dec;
  logic             out_free;

  assign accept   = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_chan.ready;

  // slot evaluated this cycle is the one read in the previous cycle
  assign ev_slot   = SAW'(scan_r - SCW'(1));
  assign ev_valid  = sm_valid[ev_slot];
  assign ev_worker = WID_W'(lscan_r - CFG_W'(1));
  assign tgt_ok    = 32'(tgt_r) < 32'(MAX_WORKERS);
  assign pend_dec  = (ent_r.pending != '0) ? ent_r.pending - CNT_W'(1) : '0;

  always_comb begin
    state_nxt      = state_r;
    scan_nxt       = scan_r;
    found_nxt      = found_r;
    slot_nxt       = slot_r;
    free_found_nxt = free_found_r;
    free_nxt       = free_r;
    ent_nxt        = ent_r;
    lscan_nxt      = lscan_r;
    best_nxt       = best_r;
    best_load_nxt  = best_load_r;
    tgt_nxt        = tgt_r;
    status_nxt     = status_r;
    clr_nxt        = clr_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_worker_nxt = out_worker_r;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;

    ld_we     = 1'b0;
    ld_waddr  = WAW'(tgt_r);
    ld_wdata  = '0;
    ld_raddr  = WAW'(tgt_r);
    sm_we     = 1'b0;
    sm_waddr  = slot_r;
    sm_wdata  = '0;
    sm_wvalid = 1'b0;
    sm_raddr  = SAW'(scan_r);

    unique case (state_r)
      S_CLEAR: begin
        // zero the load memory after reset
        ld_we    = 1'b1;
        ld_waddr = clr_r;
        clr_nxt  = clr_r + WAW'(1);
        if (clr_r == WAW'(MAX_WORKERS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          scan_nxt       = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = S_SRC_SCAN;
        end
      end

      S_SRC_SCAN: begin
        // first matching slot and first free slot, lowest index wins
        if (scan_r != '0) begin
          if (ev_valid && sm_rdata.key == src_r && !found_r) begin
            found_nxt = 1'b1;
            slot_nxt  = ev_slot;
            ent_nxt   = sm_rdata;
          end
          if (!ev_valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_nxt       = ev_slot;
          end
        end
        scan_nxt = scan_r + SCW'(1);
        if (scan_r == SCW'(SOURCE_SLOTS)) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (cmd_r == CMD_FINISH) begin
          tgt_nxt    = wid_r;
          status_nxt = ST_FIN_OK;
          if (found_r) begin
            // count down, free the slot when it drains
            sm_we    = 1'b1;
            sm_waddr = slot_r;
            if (pend_dec == '0) begin
              sm_wdata  = '0;
              sm_wvalid = 1'b0;
            end else begin
              sm_wdata.key     = ent_r.key;
              sm_wdata.pending = pend_dec;
              sm_wdata.worker  = ent_r.worker;
              sm_wvalid        = 1'b1;
            end
          end
          state_nxt = S_LOAD_RD;
        end else if (found_r && fifo_keep_r) begin
          // affinity: stay on the recorded worker
          tgt_nxt          = ent_r.worker;
          status_nxt       = ST_AFFINITY;
          sm_we            = 1'b1;
          sm_waddr         = slot_r;
          sm_wdata.key     = ent_r.key;
          sm_wdata.pending = (ent_r.pending != '1) ? ent_r.pending + CNT_W'(1)
                                                   : ent_r.pending;
          sm_wdata.worker  = ent_r.worker;
          sm_wvalid        = 1'b1;
          state_nxt        = S_LOAD_RD;
        end else begin
          lscan_nxt = '0;
          state_nxt = S_LOAD_SCAN;
        end
      end

      S_LOAD_SCAN: begin
        // strict less-than keeps the lowest index on ties
        ld_raddr = WAW'(lscan_r);
        if (lscan_r != '0) begin
          if (lscan_r == CFG_W'(1) || ld_rdata < best_load_r) begin
            best_nxt      = ev_worker;
            best_load_nxt = ld_rdata;
          end
        end
        lscan_nxt = lscan_r + CFG_W'(1);
        if (lscan_r == n_act) begin
          state_nxt = S_SRC_WR;
        end
      end

      S_SRC_WR: begin
        tgt_nxt = best_r;
        if (found_r || free_found_r) begin
          sm_we            = 1'b1;
          sm_waddr         = found_r ? slot_r : free_r;
          sm_wdata.key     = src_r;
          sm_wdata.pending = CNT_W'(1);
          sm_wdata.worker  = best_r;
          sm_wvalid        = 1'b1;
          status_nxt       = ST_LEAST;
        end else begin
          status_nxt = ST_FULL;
        end
        state_nxt = S_LOAD_RD;
      end

      S_LOAD_RD: begin
        state_nxt = S_LOAD_WR;
      end

      S_LOAD_WR: begin
        // load read back, update and present the result
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_tag_nxt    = tag_r;
          out_status_nxt = status_r;
          out_worker_nxt = tgt_r;
          if (cmd_r == CMD_FINISH) begin
            out_worker_nxt = '0;
            if (tgt_ok) begin
              if (ld_rdata == '0) begin
                out_status_nxt = ST_FIN_UNDER;
              end else begin
                ld_we    = 1'b1;
                ld_wdata = ld_rdata - LOAD_W'(1);
              end
            end
          end else if (tgt_ok && ld_rdata != '1) begin
            ld_we    = 1'b1;
            ld_wdata = ld_rdata + LOAD_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_chan.cmd;
      src_r <= in_chan.source_id;
      wid_r <= in_chan.worker_id;
      tag_r <= in_chan.task_tag;
    end
    scan_r       <= scan_nxt;
    found_r      <= found_nxt;
    slot_r       <= slot_nxt;
    free_found_r <= free_found_nxt;
    free_r       <= free_nxt;
    ent_r        <= ent_nxt;
    lscan_r      <= lscan_nxt;
    best_r       <= best_nxt;
    best_load_r  <= best_load_nxt;
    tgt_r        <= tgt_nxt;
    status_r     <= status_nxt;
    out_worker_r <= out_worker_nxt;
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.assigned_worker = out_worker_r;
  assign out_chan.status          = out_status_r;
  assign out_chan.tag_out         = out_tag_r;

endmodule

`default_nettype wire

// ===== test/least_loaded_dispatch_with_affinity_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_dispatch_with_affinity_tb
// self-checking bench for the least-loaded dispatcher with source affinity
// ----------------------------------------------------------------------------
// A directed part covers field extremes, load underflow, a full source table,
// affinity on a worker that is no longer active and affinity switched off.
// Random phases under several register settings follow: mostly well-formed
// submit/finish pairs over a small source pool, with some noise. Each accepted
// transaction is predicted by a behavioral dispatcher and results are
// compared in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module least_loaded_dispatch_with_affinity_tb;
  import lldwa_pkg::*;

  localparam int NWORK      = DEF_MAX_WORKERS;
  localparam int NSLOT      = DEF_SOURCE_SLOTS;
  localparam int IDLE_LIMIT = 4000;  // cycles without any transaction
  localparam int SETTLE     = 80;    // longest item plus margin

  typedef struct packed {
    logic [WID_W-1:0] worker;
    status_t          status;
    logic [TAG_W-1:0] tag;
  } dispatch_t;

  typedef struct packed {
    logic [SRC_W-1:0] src;
    logic [WID_W-1:0] worker;
  } open_task_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  lldwa_in_if  in_bus ();
  lldwa_out_if out_bus ();

  least_loaded_dispatch_with_affinity i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_bus.sink),
    .out_chan  (out_bus.source),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // dispatcher state as the bench sees it
  logic [LOAD_W-1:0] load_q [NWORK];
  bit                slot_used [NSLOT];
  logic [SRC_W-1:0]  slot_key [NSLOT];
  logic [CNT_W-1:0]  slot_cnt [NSLOT];
  logic [WID_W-1:0]  slot_wkr [NSLOT];
  bit                keep_q;
  logic [CFG_W-1:0]  workers_q;

  dispatch_t  pending_results [$];
  open_task_t open_tasks [$];
  int         errors;
  int         idle_cycles;
  bit         in_gaps;        // sender idles between transactions
  bit         out_stalls;     // receiver stalls at random
  int         hold_req;       // long receiver hold-off, taken by the ready process
  int         hold_left;
  int         stall_left;

  // gap length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // one transaction through the dispatcher, state updated in place
  function automatic dispatch_t dispatch_predict(logic [CMD_W-1:0] cmd,
                                                 logic [SRC_W-1:0] src,
                                                 logic [WID_W-1:0] wid,
                                                 logic [TAG_W-1:0] tag);
    dispatch_t r;
    int slot;
    int n;
    int best;
    slot = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (slot < 0 && slot_used[i] && slot_key[i] == src) slot = i;
    end
    r.tag = tag;
    r.worker = '0;
    if (cmd == CMD_SUBMIT) begin
      if (slot >= 0 && keep_q) begin
        if (slot_cnt[slot] != '1) slot_cnt[slot]++;
        r.worker = slot_wkr[slot];
        r.status = ST_AFFINITY;
      end else begin
        // active count clamps to 1..NWORK
        n = workers_q;
        if (n < 1) n = 1;
        if (n > NWORK) n = NWORK;
        best = 0;
        for (int i = 1; i < n; i++) begin
          if (load_q[i] < load_q[best]) best = i;
        end
        r.worker = best[WID_W-1:0];
        if (slot < 0) begin
          for (int i = 0; i < NSLOT; i++) begin
            if (slot < 0 && !slot_used[i]) slot = i;
          end
        end
        if (slot >= 0) begin
          slot_used[slot] = 1'b1;
          slot_key[slot]  = src;
          slot_cnt[slot]  = CNT_W'(1);
          slot_wkr[slot]  = r.worker;
          r.status = ST_LEAST;
        end else begin
          r.status = ST_FULL;  // dispatched but not recorded
        end
      end
      if (load_q[r.worker] != '1) load_q[r.worker]++;
    end else begin
      r.status = ST_FIN_OK;
      if (load_q[wid] == '0) r.status = ST_FIN_UNDER;
      else load_q[wid]--;
      if (slot >= 0) begin
        if (slot_cnt[slot] != '0) slot_cnt[slot]--;
        if (slot_cnt[slot] == '0) begin
          slot_used[slot] = 1'b0;
          slot_key[slot]  = '0;
          slot_wkr[slot]  = '0;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // offer one transaction; valid stays high afterwards unless a gap follows
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [SRC_W-1:0] src,
                           logic [WID_W-1:0] wid, logic [TAG_W-1:0] tag);
    int gap;
    dispatch_t r;
    gap = in_gaps && $urandom_range(0, 2) != 0 ? pick_gap() : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.cmd       <= cmd;
    in_bus.source_id <= src;
    in_bus.worker_id <= wid;
    in_bus.task_tag  <= tag;
    // ready is stable between edges, so look at it mid-cycle
    do @(negedge clk); while (!in_bus.ready);
    @(posedge clk);
    r = dispatch_predict(cmd, src, wid, tag);
    pending_results.insert(pending_results.size(), r);
    if (cmd == CMD_SUBMIT) begin
      open_tasks.insert(open_tasks.size(), '{src: src, worker: r.worker});
    end else begin
      foreach (open_tasks[i]) begin
        if (open_tasks[i].src == src && open_tasks[i].worker == wid) begin
          open_tasks.delete(i);
          break;
        end
      end
    end
  endtask

  task automatic stop_sending();
    in_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FIFO_KEEP) keep_q = data[0];
    else workers_q = data;
  endtask

  // result channel ready: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (out_stalls && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap() - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // result checker: a transaction completes at the edge after this sample
  always @(negedge clk) begin
    dispatch_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result tag %0d at %0t", out_bus.tag_out, $realtime);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_bus.assigned_worker !== want.worker)
          report_mismatch("assigned_worker", out_bus.assigned_worker, want.worker);
        if (out_bus.status !== want.status)
          report_mismatch("status", out_bus.status, want.status);
        if (out_bus.tag_out !== want.tag)
          report_mismatch("tag_out", out_bus.tag_out, want.tag);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---- tests -----------------------------------------------------------------

  // extreme field values; a finish on an idle worker underflows
  task automatic test_field_extremes();
    send_item(CMD_SUBMIT, 16'h0000, 4'h0, 16'h0000);
    send_item(CMD_SUBMIT, 16'hFFFF, 4'hF, 16'hFFFF);
    send_item(CMD_FINISH, 16'hFFFF, 4'hF, 16'hA5A5);  // worker 15 idle, source freed
    send_item(CMD_FINISH, 16'h0000, 4'h0, 16'h5A5A);
    send_item(CMD_FINISH, 16'h1234, 4'h0, 16'h0001);  // unknown source, underflow
  endtask

  // seventeen distinct sources overflow a sixteen-slot table
  task automatic test_table_full();
    for (int i = 0; i < NSLOT + 1; i++)
      send_item(CMD_SUBMIT, SRC_W'(16'h8000 + i), 4'h0,
                TAG_W'($urandom_range(0, 65535)));
  endtask

  // affinity to a worker outside the active range, then affinity off
  task automatic test_affinity_rules();
    write_reg(CFG_WORKERS, 5'd1);
    send_item(CMD_SUBMIT, 16'h8005, 4'h0, 16'h0F0F);  // keeps worker 6
    write_reg(CFG_FIFO_KEEP, 5'd0);
    send_item(CMD_SUBMIT, 16'h8005, 4'h0, 16'hF0F0);  // re-picked, slot rewritten
    write_reg(CFG_WORKERS, 5'd0);                     // acts as one worker
    send_item(CMD_SUBMIT, 16'h8003, 4'h0, 16'h1111);
    write_reg(CFG_WORKERS, 5'd31);                    // acts as all workers
    write_reg(CFG_FIFO_KEEP, 5'd1);
  endtask

  // receiver holds off long while the sender keeps offering
  task automatic test_backpressure();
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk);
    in_gaps  = 0;
    hold_req = 400;
    for (int i = 0; i < 20; i++)
      send_item(CMD_SUBMIT, SRC_W'($urandom_range(0, 65535)),
                WID_W'($urandom_range(0, 15)), TAG_W'($urandom_range(0, 65535)));
    in_gaps = 1;
  endtask

  // mostly well-formed traffic from a small source pool, some noise
  task automatic test_random_traffic(int count, logic [CFG_W-1:0] nwork, bit keep);
    logic [SRC_W-1:0] pool [24];
    int k;
    write_reg(CFG_WORKERS, nwork);
    write_reg(CFG_FIFO_KEEP, {4'd0, keep});
    foreach (pool[i]) pool[i] = SRC_W'($urandom_range(0, 65535));
    for (int i = 0; i < count; i++) begin
      // stretches without receiver stalls now and then
      if (i % 100 == 0) out_stalls = $urandom_range(0, 3) != 0;
      k = $urandom_range(0, 99);
      if (k < 50 || (k < 90 && open_tasks.size() == 0)) begin
        send_item(CMD_SUBMIT, pool[$urandom_range(0, 23)], WID_W'($urandom_range(0, 15)),
                  TAG_W'($urandom_range(0, 65535)));
      end else if (k < 90) begin
        k = $urandom_range(0, open_tasks.size() - 1);
        send_item(CMD_FINISH, open_tasks[k].src, open_tasks[k].worker,
                  TAG_W'($urandom_range(0, 65535)));
      end else begin
        send_item(CMD_W'($urandom_range(0, 1)), SRC_W'($urandom_range(0, 65535)),
                  WID_W'($urandom_range(0, 15)), TAG_W'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.cmd = CMD_SUBMIT;
    in_bus.source_id = '0;
    in_bus.worker_id = '0;
    in_bus.task_tag = '0;
    out_bus.ready = 1'b0;
    errors = 0;
    idle_cycles = 0;
    hold_req = 0;
    in_gaps = 1;
    out_stalls = 1;
    keep_q = 1'b1;
    workers_q = WORKERS_RESET;
    for (int i = 0; i < NWORK; i++) load_q[i] = '0;
    for (int i = 0; i < NSLOT; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
      slot_cnt[i]  = '0;
      slot_wkr[i]  = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_table_full();
    test_affinity_rules();
    test_backpressure();
    test_random_traffic(250, 5'd16, 1'b1);
    test_random_traffic(200, 5'd1, 1'b1);
    test_random_traffic(200, 5'd3, 1'b0);
    test_random_traffic(250, CFG_W'($urandom_range(2, 15)), 1'b1);

    stop_sending();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/lldwa_pkg.sv
sv/lldwa_if.sv
sv/lldwa_load_mem.sv
sv/lldwa_src_mem.sv
sv/least_loaded_dispatch_with_affinity.sv
test/least_loaded_dispatch_with_affinity_tb.sv
